>>> rtl/luinv_pkg.sv
// ----------------------------------------------------------------------------
// luinv_pkg
// shared constants, types and fixed-point helpers for the lu inverse core
// ----------------------------------------------------------------------------
package luinv_pkg;

	localparam int MAX_DIM = 8;
	localparam int IW      = 48;
	localparam int IFRAC   = IW / 2;
	localparam int CELLS   = MAX_DIM * MAX_DIM;
	localparam int CA_W    = $clog2(CELLS);
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// one loaded word on its way from the front to the back
	typedef struct packed {
		logic [31:0]     value;
		logic [CA_W-1:0] addr;
		logic            last;
		logic [3:0]      n;
	} q_entry_t;

	// one result word
	typedef struct packed {
		logic        strobe;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic [63:0] det;
		logic        singular;
		logic        sat;
		logic        last;
	} res_t;

	function automatic logic [47:0] mag48(input logic [47:0] x);
		return x[47] ? (~x + 48'd1) : x;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	// saturating subtract, msb of result is the clip flag
	function automatic logic [48:0] sub_sat(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] d;
		d = {a[47], a} - {b[47], b};
		if (d[48] != d[47])
			return {1'b1, d[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}};
		return {1'b0, d[47:0]};
	endfunction

	// sign-magnitude to two's complement, clipped to 48 or 64 bits
	function automatic logic [64:0] sat_pack(input logic neg, input logic [111:0] m,
			input logic wide);
		logic [111:0] lim;
		logic [63:0]  v;
		logic         s;
		lim = wide ? ((112'd1 << 63) - 112'(!neg)) : ((112'd1 << 47) - 112'(!neg));
		s   = m > lim;
		v   = s ? lim[63:0] : m[63:0];
		if (neg)
			v = ~v + 64'd1;
		return {s, v};
	endfunction

	// internal value to output q16.16 with rounding and clipping
	function automatic logic [32:0] pack_out(input logic [47:0] x);
		logic [47:0] m;
		logic [48:0] r;
		logic [48:0] lim;
		logic [31:0] v;
		logic        s;
		m   = mag48(x);
		r   = ({1'b0, m} + 49'd128) >> (IFRAC - 16);
		lim = x[47] ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
		s   = r > lim;
		v   = s ? lim[31:0] : r[31:0];
		if (x[47])
			v = ~v + 32'd1;
		return {s, v};
	endfunction

	// flat store address of row r, column c at dimension n
	function automatic logic [CA_W-1:0] idx(input logic [2:0] r, input logic [2:0] c,
			input logic [3:0] n);
		logic [6:0] t;
		t = 7'(r) * 7'(n) + 7'(c);
		return t[CA_W-1:0];
	endfunction

endpackage

>>> rtl/lu_matrix_inverse_and_determinant_core.sv
// loading: elements load one per cycle through a four-word queue while busy
//   is low; after the closing element a run is set by the waits on the
//   bit-serial divider (about 3n^2/2 divides) and on the shared multiplier
// throughput: one matrix per run; result words never leave back to back
// reset: arst_n clears the sequencer, queue, load count and sets n to 8
// results carry a one-cycle strobe and cannot be held off by the receiver
// ----------------------------------------------------------------------------
// lu_matrix_inverse_and_determinant_core
// crout lu with partial pivoting giving inverse and determinant in fixed point
// ----------------------------------------------------------------------------
module lu_matrix_inverse_and_determinant_core (
	input  logic               clk,
	input  logic               arst_n,
	// element word
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] element_value,
	// size register write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	// result word
	output logic               result_strobe,
	output logic [2:0]         inv_row,
	output logic [2:0]         inv_col,
	output logic signed [31:0] inv_value,
	output logic signed [63:0] determinant,
	output logic               singular,
	output logic               saturated,
	output logic               last
);
	import luinv_pkg::*;

	// front to queue
	logic     push;
	q_entry_t push_word;
	logic     q_full;
	// queue to back
	logic     q_valid;
	logic     q_pop;
	q_entry_t q_word;
	// back to ports
	res_t     res;

	// front: handshake, size register and load counter
	luinv_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.element_value (element_value),
		.q_full        (q_full),
		.busy          (busy),
		.cfg_ready     (cfg_ready),
		.push          (push),
		.entry         (push_word)
	);

	// decouples loading from a running solve
	luinv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_word),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_word),
		.full   (q_full)
	);

	// back: matrix store, decomposition, inverse and determinant
	luinv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_word),
		.q_pop   (q_pop),
		.res     (res)
	);

	assign result_strobe = res.strobe;
	assign inv_row       = res.row;
	assign inv_col       = res.col;
	assign inv_value     = res.value;
	assign determinant   = res.det;
	assign singular      = res.singular;
	assign saturated     = res.sat;
	assign last          = res.last;

endmodule

>>> rtl/luinv_front.sv
// ----------------------------------------------------------------------------
// luinv_front
// takes elements, counts the load and marks the word that closes a matrix
// ----------------------------------------------------------------------------
module luinv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                cfg_valid,
	input  logic [3:0]          cfg_data,
	input  logic [31:0]         element_value,
	input  logic                q_full,
	output logic                busy,
	output logic                cfg_ready,
	output logic                push,
	output luinv_pkg::q_entry_t entry
);
	import luinv_pkg::*;

	logic [3:0] size_q;
	logic [6:0] cnt_q;
	logic [3:0] n;
	logic [6:0] cnt_nx;
	logic       closes;

	assign busy      = q_full;
	assign cfg_ready = 1'b1;
	assign push      = start && !q_full;

	always_comb begin
		if (size_q == 4'd0)
			n = 4'd1;
		else if (size_q > 4'(MAX_DIM))
			n = 4'(MAX_DIM);
		else
			n = size_q;
	end

	assign cnt_nx = cnt_q + 7'd1;
	assign closes = cnt_nx >= 7'(n) * 7'(n);

	assign entry.value = element_value;
	assign entry.addr  = cnt_q[CA_W-1:0];
	assign entry.last  = closes;
	assign entry.n     = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd8;
			cnt_q  <= 7'd0;
		end else begin
			if (cfg_valid && cfg_ready)
				size_q <= cfg_data;
			if (push)
				cnt_q <= closes ? 7'd0 : cnt_nx;
		end
	end

endmodule

>>> rtl/luinv_queue.sv
// ----------------------------------------------------------------------------
// luinv_queue
// short fifo between the loading front and the solver back
// ----------------------------------------------------------------------------
module luinv_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  luinv_pkg::q_entry_t wdata,
	input  logic                pop,
	output logic                valid,
	output luinv_pkg::q_entry_t rdata,
	output logic                full
);
	import luinv_pkg::*;

	q_entry_t        buf_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;

	assign valid = cnt_q != '0;
	assign full  = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/luinv_mul.sv
// ----------------------------------------------------------------------------
// luinv_mul
// 64 x 48 unsigned multiplier, four 32 x 24 partial products over cycles
// ----------------------------------------------------------------------------
module luinv_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [63:0]  a,
	input  logic [47:0]  b,
	output logic         done,
	output logic [111:0] prod
);
	logic [63:0]  a_q;
	logic [47:0]  b_q;
	logic [2:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [55:0]  p_q;
	logic [1:0]   pi_q;
	logic [111:0] acc_q;
	logic [31:0]  ma;
	logic [23:0]  mb;
	logic [55:0]  part;
	logic [111:0] shf;

	assign done = done_q;
	assign prod = acc_q;

	always_comb begin
		ma = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		mb = cnt_q[0] ? b_q[47:24] : b_q[23:0];
		part = ma * mb;
		case (pi_q)
			2'd0:    shf = 112'(p_q);
			2'd1:    shf = 112'(p_q) << 24;
			2'd2:    shf = 112'(p_q) << 32;
			2'd3:    shf = 112'(p_q) << 56;
			default: shf = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				a_q   <= a;
				b_q   <= b;
				cnt_q <= 3'd0;
				run_q <= 1'b1;
				acc_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q != 3'd4) begin
					p_q  <= part;
					pi_q <= cnt_q[1:0];
				end
				if (cnt_q != 3'd0)
					acc_q <= acc_q + shf;
				if (cnt_q == 3'd4) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/luinv_div.sv
// ----------------------------------------------------------------------------
// luinv_div
// restoring divider, (a << 24) / d one bit a cycle, rounded to nearest
// ----------------------------------------------------------------------------
module luinv_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] a,
	input  logic [47:0] d,
	output logic        done,
	output logic [72:0] quo
);
	logic [71:0] num_q;
	logic [47:0] rem_q;
	logic [71:0] quo_q;
	logic [47:0] d_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        fin_q;
	logic        done_q;
	logic [72:0] qo_q;
	logic [48:0] t;
	logic [48:0] diff;
	logic        ge;

	assign done = done_q;
	assign quo  = qo_q;

	assign t    = {rem_q, num_q[71]};
	assign diff = t - {1'b0, d_q};
	assign ge   = t >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				num_q <= {a, 24'd0};
				rem_q <= '0;
				quo_q <= '0;
				d_q   <= d;
				cnt_q <= 7'd0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? diff[47:0] : t[47:0];
				quo_q <= {quo_q[70:0], ge};
				num_q <= {num_q[70:0], 1'b0};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd71) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				qo_q   <= 73'(quo_q) + 73'(rem_q >= d_q - rem_q);
				done_q <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/luinv_back.sv
// ----------------------------------------------------------------------------
// luinv_back
// sequencer: stores the matrix, crout lu with pivoting, inverse, determinant
// ----------------------------------------------------------------------------
module luinv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  luinv_pkg::q_entry_t q_data,
	output logic                q_pop,
	output luinv_pkg::res_t     res
);
	import luinv_pkg::*;

	localparam logic [5:0] S_LOAD = 6'd0,  S_SC_RD = 6'd1,  S_SC_AC = 6'd2,  S_SING = 6'd3;
	localparam logic [5:0] S_CJ_RD = 6'd4, S_CJ_S = 6'd5,   S_CJ_L1 = 6'd6,  S_CJ_L2 = 6'd7;
	localparam logic [5:0] S_CJ_L3 = 6'd8, S_CJ_L5 = 6'd9,  S_CJ_WR = 6'd10, S_CJ_C1 = 6'd11;
	localparam logic [5:0] S_CJ_C2 = 6'd12, S_CJ_NX = 6'd13, S_SW = 6'd14,   S_SW1 = 6'd15;
	localparam logic [5:0] S_SW2 = 6'd16,  S_SW3 = 6'd17,   S_SW4 = 6'd18,   S_PV = 6'd19;
	localparam logic [5:0] S_PV2 = 6'd20,  S_DV1 = 6'd21,   S_DV2 = 6'd22,   S_DV3 = 6'd23;
	localparam logic [5:0] S_NXC = 6'd24,  S_IV0 = 6'd25,   S_FW1 = 6'd26,   S_FW2 = 6'd27;
	localparam logic [5:0] S_FW3 = 6'd28,  S_FW4 = 6'd29,   S_FW45 = 6'd30,  S_FW5 = 6'd31;
	localparam logic [5:0] S_BK1 = 6'd32,  S_BK2 = 6'd33,   S_BK3 = 6'd34,   S_BK35 = 6'd35;
	localparam logic [5:0] S_BK4 = 6'd36,  S_BK5 = 6'd37,   S_BK6 = 6'd38,   S_WI = 6'd39;
	localparam logic [5:0] S_DT0 = 6'd40,  S_DT1 = 6'd41,   S_DT2 = 6'd42,   S_DT3 = 6'd43;
	localparam logic [5:0] S_OUT1 = 6'd44, S_OUT2 = 6'd45,  S_MULW = 6'd46,  S_DIVW = 6'd47;

	localparam logic [47:0]  ONE_I = 48'd1 << IFRAC;
	localparam logic [111:0] RND   = 112'd1 << (IFRAC - 1);

	logic [5:0]  state_q, ret_q;
	logic [3:0]  n_q, i_q, j_q, l_q, c_q;
	logic [2:0]  best_q, ip_q;
	logic [47:0] s_q, x_q, r_q, best_mag_q, piv_q;
	logic [63:0] t_q, det_q;
	logic [95:0] p1_q;
	logic        sign_q, sat_q;
	logic        mul_neg_q, mul_wide_q, mul_raw_q, div_neg_q;
	logic [47:0] rs_q [MAX_DIM];
	logic [2:0]  pidx_q [MAX_DIM];
	logic [47:0] b_q [MAX_DIM];
	res_t        res_q;

	logic [47:0]     mat_mem [CELLS];
	logic [47:0]     inv_mem [CELLS];
	logic [CA_W-1:0] m_ra, m_wa, inv_ra, inv_wa;
	logic [47:0]     m_wd, m_rd, inv_rd;
	logic            m_we, inv_we;

	logic         mul_go, mul_done, div_go, div_done;
	logic [63:0]  mul_a;
	logic [47:0]  mul_b, div_a, div_d;
	logic [111:0] mul_prod, mul_rnd;
	logic [72:0]  div_quo;

	logic [2:0]  b_ra, rs_ra;
	logic [47:0] b_rd, rs_rd;
	logic [3:0]  lim;
	logic [47:0] m_mag, nr;
	logic [48:0] sub_r;
	logic [64:0] mpk, dpk;
	logic [32:0] opk;
	logic [2:0]  ii, jj, ll, cc;

	assign res = res_q;
	assign ii  = i_q[2:0];
	assign jj  = j_q[2:0];
	assign ll  = l_q[2:0];
	assign cc  = c_q[2:0];

	assign b_rd    = b_q[b_ra];
	assign rs_rd   = rs_q[rs_ra];
	assign lim     = (i_q < j_q) ? i_q : j_q;
	assign m_mag   = mag48(m_rd);
	assign nr      = (m_mag > r_q) ? m_mag : r_q;
	assign sub_r   = sub_sat(s_q, t_q[47:0]);
	assign mul_rnd = (mul_prod + RND) >> IFRAC;
	assign mpk     = sat_pack(mul_neg_q, mul_rnd, mul_wide_q);
	assign dpk     = sat_pack(div_neg_q, 112'(div_quo), 1'b0);
	assign opk     = pack_out(inv_rd);
	assign q_pop   = (state_q == S_LOAD) && q_valid;

	luinv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	luinv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.a      (div_a),
		.d      (div_d),
		.done   (div_done),
		.quo    (div_quo)
	);

	// matrix and inverse stores, registered read
	always_ff @(posedge clk) begin
		if (m_we)
			mat_mem[m_wa] <= m_wd;
		m_rd <= mat_mem[m_ra];
	end

	always_ff @(posedge clk) begin
		if (inv_we)
			inv_mem[inv_wa] <= b_rd;
		inv_rd <= inv_mem[inv_ra];
	end

	// addresses and unit starts
	always_comb begin
		m_ra   = idx(ii, jj, n_q);
		m_wa   = idx(ii, jj, n_q);
		m_wd   = s_q;
		m_we   = 1'b0;
		inv_ra = idx(ii, jj, n_q);
		inv_wa = idx(ii, cc, n_q);
		inv_we = 1'b0;
		mul_go = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		div_go = 1'b0;
		div_a  = '0;
		div_d  = '0;
		b_ra   = ii;
		rs_ra  = ii;
		case (state_q)
			S_LOAD: begin
				if (q_valid) begin
					m_we = 1'b1;
					m_wa = q_data.addr;
					m_wd = {{8{q_data.value[31]}}, q_data.value, 8'd0};
				end
			end
			S_CJ_L1: m_ra = idx(ii, ll, n_q);
			S_CJ_L2: m_ra = idx(ll, jj, n_q);
			S_CJ_L3: begin
				mul_go = 1'b1;
				mul_a  = 64'(mag48(x_q));
				mul_b  = m_mag;
			end
			S_CJ_WR: begin
				m_we  = 1'b1;
				rs_ra = best_q;
				if (i_q > j_q) begin
					mul_go = 1'b1;
					mul_a  = 64'(mag48(s_q));
					mul_b  = rs_rd;
				end
			end
			S_CJ_C1: begin
				mul_go = 1'b1;
				mul_a  = 64'(best_mag_q);
				mul_b  = rs_rd;
			end
			S_SW1: m_ra = idx(best_q, cc, n_q);
			S_SW2: m_ra = idx(jj, cc, n_q);
			S_SW3: begin
				m_we = 1'b1;
				m_wa = idx(best_q, cc, n_q);
				m_wd = m_rd;
			end
			S_SW4: begin
				m_we  = 1'b1;
				m_wa  = idx(jj, cc, n_q);
				m_wd  = x_q;
				rs_ra = jj;
			end
			S_PV: m_ra = idx(jj, jj, n_q);
			S_PV2: begin
				m_wa = idx(jj, jj, n_q);
				m_wd = 48'd1;
				m_we = m_rd == '0;
			end
			S_DV2: begin
				div_go = 1'b1;
				div_a  = m_mag;
				div_d  = mag48(piv_q);
			end
			S_DV3: m_wd = t_q[47:0];
			S_FW1: b_ra = pidx_q[ii];
			S_FW3: m_ra = idx(ii, ll, n_q);
			S_FW4, S_BK3: begin
				b_ra   = ll;
				mul_go = 1'b1;
				mul_a  = 64'(m_mag);
				mul_b  = mag48(b_rd);
			end
			S_BK2: m_ra = idx(ii, ll, n_q);
			S_BK4: m_ra = idx(ii, ii, n_q);
			S_BK5: begin
				div_go = 1'b1;
				div_a  = mag48(s_q);
				div_d  = m_mag;
			end
			S_WI: inv_we = 1'b1;
			S_DT1: m_ra = idx(jj, jj, n_q);
			S_DT2: begin
				mul_go = 1'b1;
				mul_a  = mag64(det_q);
				mul_b  = m_mag;
			end
			default: ;
		endcase
		if (state_q == S_DV3)
			m_we = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			res_q.strobe <= 1'b0;
			sign_q       <= 1'b0;
			sat_q        <= 1'b0;
		end else begin
			res_q.strobe <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (q_valid && q_data.last) begin
						n_q     <= q_data.n;
						i_q     <= 4'd0;
						j_q     <= 4'd0;
						r_q     <= '0;
						sat_q   <= 1'b0;
						sign_q  <= 1'b0;
						state_q <= S_SC_RD;
					end
				end
				// largest magnitude of each row
				S_SC_RD: state_q <= S_SC_AC;
				S_SC_AC: begin
					if (j_q + 4'd1 == n_q) begin
						if (nr == '0) begin
							state_q <= S_SING;
						end else begin
							rs_q[ii] <= nr;
							r_q      <= '0;
							j_q      <= 4'd0;
							if (i_q + 4'd1 == n_q) begin
								i_q     <= 4'd0;
								state_q <= S_CJ_RD;
							end else begin
								i_q     <= i_q + 4'd1;
								state_q <= S_SC_RD;
							end
						end
					end else begin
						r_q     <= nr;
						j_q     <= j_q + 4'd1;
						state_q <= S_SC_RD;
					end
				end
				S_SING: begin
					res_q.strobe   <= 1'b1;
					res_q.row      <= 3'd0;
					res_q.col      <= 3'd0;
					res_q.value    <= '0;
					res_q.det      <= '0;
					res_q.singular <= 1'b1;
					res_q.sat      <= 1'b0;
					res_q.last     <= 1'b1;
					state_q        <= S_LOAD;
				end
				// column j, row i: reduce by earlier terms
				S_CJ_RD: begin
					l_q     <= 4'd0;
					state_q <= S_CJ_S;
				end
				S_CJ_S: begin
					s_q     <= m_rd;
					state_q <= (lim == 4'd0) ? S_CJ_WR : S_CJ_L1;
				end
				S_CJ_L1: state_q <= S_CJ_L2;
				S_CJ_L2: begin
					x_q     <= m_rd;
					state_q <= S_CJ_L3;
				end
				S_CJ_L3: begin
					mul_neg_q  <= x_q[47] ^ m_rd[47];
					mul_wide_q <= 1'b0;
					mul_raw_q  <= 1'b0;
					ret_q      <= S_CJ_L5;
					state_q    <= S_MULW;
				end
				S_CJ_L5: begin
					s_q     <= sub_r[47:0];
					sat_q   <= sat_q | sub_r[48];
					l_q     <= l_q + 4'd1;
					state_q <= (l_q + 4'd1 == lim) ? S_CJ_WR : S_CJ_L1;
				end
				S_CJ_WR: begin
					if (i_q == j_q) begin
						best_q     <= jj;
						best_mag_q <= mag48(s_q);
						state_q    <= S_CJ_NX;
					end else if (i_q > j_q) begin
						mul_raw_q <= 1'b1;
						ret_q     <= S_CJ_C1;
						state_q   <= S_MULW;
					end else begin
						state_q <= S_CJ_NX;
					end
				end
				// pivot compare by cross multiplication, later row wins a tie
				S_CJ_C1: begin
					p1_q    <= mul_prod[95:0];
					ret_q   <= S_CJ_C2;
					state_q <= S_MULW;
				end
				S_CJ_C2: begin
					if (p1_q >= mul_prod[95:0]) begin
						best_q     <= ii;
						best_mag_q <= mag48(s_q);
					end
					state_q <= S_CJ_NX;
				end
				S_CJ_NX: begin
					if (i_q + 4'd1 == n_q) begin
						state_q <= S_SW;
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= S_CJ_RD;
					end
				end
				// row swap
				S_SW: begin
					c_q     <= 4'd0;
					state_q <= (best_q != jj) ? S_SW1 : S_PV;
				end
				S_SW1: state_q <= S_SW2;
				S_SW2: begin
					x_q     <= m_rd;
					state_q <= S_SW3;
				end
				S_SW3: state_q <= S_SW4;
				S_SW4: begin
					c_q <= c_q + 4'd1;
					if (c_q + 4'd1 == n_q) begin
						sign_q       <= ~sign_q;
						rs_q[best_q] <= rs_rd;
						state_q      <= S_PV;
					end else begin
						state_q <= S_SW1;
					end
				end
				S_PV: begin
					pidx_q[jj] <= best_q;
					state_q    <= S_PV2;
				end
				S_PV2: begin
					piv_q <= (m_rd == '0) ? 48'd1 : m_rd;
					i_q   <= j_q + 4'd1;
					state_q <= (j_q + 4'd1 == n_q) ? S_NXC : S_DV1;
				end
				S_DV1: state_q <= S_DV2;
				S_DV2: begin
					div_neg_q <= m_rd[47] ^ piv_q[47];
					ret_q     <= S_DV3;
					state_q   <= S_DIVW;
				end
				S_DV3: begin
					i_q     <= i_q + 4'd1;
					state_q <= (i_q + 4'd1 == n_q) ? S_NXC : S_DV1;
				end
				S_NXC: begin
					i_q <= 4'd0;
					if (j_q + 4'd1 == n_q) begin
						c_q     <= 4'd0;
						state_q <= S_IV0;
					end else begin
						j_q     <= j_q + 4'd1;
						state_q <= S_CJ_RD;
					end
				end
				// one unit column at a time
				S_IV0: begin
					for (int k = 0; k < MAX_DIM; k++)
						b_q[k] <= (3'(k) == cc) ? ONE_I : '0;
					i_q     <= 4'd0;
					state_q <= S_FW1;
				end
				S_FW1: begin
					s_q     <= b_rd;
					ip_q    <= pidx_q[ii];
					state_q <= S_FW2;
				end
				S_FW2: begin
					b_q[ip_q] <= b_rd;
					l_q       <= 4'd0;
					state_q   <= (i_q == 4'd0) ? S_FW5 : S_FW3;
				end
				S_FW3: state_q <= S_FW4;
				S_FW4: begin
					mul_neg_q  <= m_rd[47] ^ b_rd[47];
					mul_wide_q <= 1'b0;
					mul_raw_q  <= 1'b0;
					ret_q      <= S_FW45;
					state_q    <= S_MULW;
				end
				S_FW45: begin
					s_q     <= sub_r[47:0];
					sat_q   <= sat_q | sub_r[48];
					l_q     <= l_q + 4'd1;
					state_q <= (l_q + 4'd1 == i_q) ? S_FW5 : S_FW3;
				end
				S_FW5: begin
					b_q[ii] <= s_q;
					if (i_q + 4'd1 == n_q) begin
						i_q     <= n_q - 4'd1;
						state_q <= S_BK1;
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= S_FW1;
					end
				end
				S_BK1: begin
					s_q     <= b_rd;
					l_q     <= i_q + 4'd1;
					state_q <= (i_q + 4'd1 == n_q) ? S_BK4 : S_BK2;
				end
				S_BK2: state_q <= S_BK3;
				S_BK3: begin
					mul_neg_q  <= m_rd[47] ^ b_rd[47];
					mul_wide_q <= 1'b0;
					mul_raw_q  <= 1'b0;
					ret_q      <= S_BK35;
					state_q    <= S_MULW;
				end
				S_BK35: begin
					s_q     <= sub_r[47:0];
					sat_q   <= sat_q | sub_r[48];
					l_q     <= l_q + 4'd1;
					state_q <= (l_q + 4'd1 == n_q) ? S_BK4 : S_BK2;
				end
				S_BK4: state_q <= S_BK5;
				S_BK5: begin
					div_neg_q <= s_q[47] ^ m_rd[47];
					ret_q     <= S_BK6;
					state_q   <= S_DIVW;
				end
				S_BK6: begin
					b_q[ii] <= t_q[47:0];
					if (i_q == 4'd0) begin
						state_q <= S_WI;
					end else begin
						i_q     <= i_q - 4'd1;
						state_q <= S_BK1;
					end
				end
				S_WI: begin
					if (i_q + 4'd1 == n_q) begin
						if (c_q + 4'd1 == n_q) begin
							state_q <= S_DT0;
						end else begin
							c_q     <= c_q + 4'd1;
							state_q <= S_IV0;
						end
					end else begin
						i_q <= i_q + 4'd1;
					end
				end
				// determinant: pivot sign times diagonal product
				S_DT0: begin
					det_q   <= sign_q ? (64'd0 - (64'd1 << 32)) : (64'd1 << 32);
					j_q     <= 4'd0;
					state_q <= S_DT1;
				end
				S_DT1: state_q <= S_DT2;
				S_DT2: begin
					mul_neg_q  <= det_q[63] ^ m_rd[47];
					mul_wide_q <= 1'b1;
					mul_raw_q  <= 1'b0;
					ret_q      <= S_DT3;
					state_q    <= S_MULW;
				end
				S_DT3: begin
					det_q <= t_q;
					if (j_q + 4'd1 == n_q) begin
						i_q     <= 4'd0;
						j_q     <= 4'd0;
						state_q <= S_OUT1;
					end else begin
						j_q     <= j_q + 4'd1;
						state_q <= S_DT1;
					end
				end
				// emit inverse in row order
				S_OUT1: state_q <= S_OUT2;
				S_OUT2: begin
					res_q.strobe   <= 1'b1;
					res_q.row      <= ii;
					res_q.col      <= jj;
					res_q.value    <= opk[31:0];
					res_q.det      <= det_q;
					res_q.singular <= 1'b0;
					res_q.sat      <= sat_q | opk[32];
					res_q.last     <= (i_q + 4'd1 == n_q) && (j_q + 4'd1 == n_q);
					if (j_q + 4'd1 == n_q) begin
						j_q <= 4'd0;
						i_q <= i_q + 4'd1;
						state_q <= (i_q + 4'd1 == n_q) ? S_LOAD : S_OUT1;
					end else begin
						j_q     <= j_q + 4'd1;
						state_q <= S_OUT1;
					end
				end
				S_MULW: begin
					if (mul_done) begin
						t_q <= mpk[63:0];
						if (!mul_raw_q)
							sat_q <= sat_q | mpk[64];
						state_q <= ret_q;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						t_q     <= dpk[63:0];
						sat_q   <= sat_q | dpk[64];
						state_q <= ret_q;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == S_MULW)
		else $error("multiplier finished outside its wait state");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVW)
		else $error("divider finished outside its wait state");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_data.last |=> state_q == S_SC_RD)
		else $error("closing word did not start a run");

	a_words_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.strobe |=> !res_q.strobe)
		else $error("result words back to back");

	a_singular_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.strobe && res_q.singular |-> res_q.last && res_q.det == '0)
		else $error("singular result malformed");

endmodule
